[rtl/lwkd_pkg.sv]
// Shared types and constants for the longest k-distinct window block.
// No dependencies; imported by longest_window_k_distinct.
`timescale 1ns / 1ps
`default_nettype none

package lwkd_pkg;

  // Default sizing
  localparam int DEFAULT_WINDOW_DEPTH = 1024;
  localparam int DEFAULT_SYMBOL_BITS  = 8;

  // Fixed port widths
  localparam int SYM_IN_W   = 8;
  localparam int LEN_W      = 11;
  localparam int DISTINCT_W = 9;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // Register map (word index taken from paddr[2])
  localparam logic REG_MAX_DISTINCT = 1'b0;
  localparam logic [DISTINCT_W-1:0] MAX_DISTINCT_RESET = 9'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,   // sweep symbol counts to zero after reset
    ST_IDLE,    // wait for a request
    ST_DRAIN,   // new string: zero the counts of every buffered symbol
    ST_START,   // decide whether the buffer is full
    ST_DROP_A,  // read oldest buffered symbol
    ST_DROP_B,  // read its count
    ST_DROP_C,  // write back decremented count, advance head
    ST_INS_A,   // store symbol in buffer, read its count
    ST_INS_B,   // write back incremented count
    ST_CHECK    // shrink further or publish the result
  } state_t;

endpackage

`default_nettype wire

[rtl/longest_window_k_distinct.sv]
// Longest window with at most max_distinct different symbols; depends on lwkd_pkg.
// A request passes the start, insert and check states before its result is published;
// each symbol dropped to meet the limit adds a drop pass, as does an eviction from a
// full buffer; a set first adds a clearing of each buffered symbol's count, and an
// out_ready stall holds the result. A new request is taken once the last is published.
// Reset: a sweep over 2**SYMBOL_BITS entries zeroes the count memory; in_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module longest_window_k_distinct #(
  parameter int WINDOW_DEPTH = lwkd_pkg::DEFAULT_WINDOW_DEPTH,
  parameter int SYMBOL_BITS  = lwkd_pkg::DEFAULT_SYMBOL_BITS
) (
  input  wire                              clk,
  input  wire                              rst,
  // request channel
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [lwkd_pkg::SYM_IN_W-1:0]    symbol,
  input  wire                              first,
  // result channel
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [lwkd_pkg::LEN_W-1:0]       best_length,
  output logic [lwkd_pkg::LEN_W-1:0]       window_length,
  output logic [lwkd_pkg::DISTINCT_W-1:0]  distinct_count,
  output logic                             overflow,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [lwkd_pkg::APB_AW-1:0]      paddr,
  input  wire  [lwkd_pkg::APB_DW-1:0]      pwdata,
  output logic [lwkd_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  import lwkd_pkg::*;

  localparam int AW      = $clog2(WINDOW_DEPTH);
  localparam int FW      = AW + 1;
  localparam int NSYM    = 1 << SYMBOL_BITS;
  localparam int DW      = SYMBOL_BITS + 1;
  localparam int CMPW    = (DW > DISTINCT_W) ? DW : DISTINCT_W;

  // Memories
  logic [FW-1:0]          cnt_mem [NSYM];
  logic [SYMBOL_BITS-1:0] win_mem [WINDOW_DEPTH];

  // Memory ports
  logic                   cnt_re, cnt_we;
  logic [SYMBOL_BITS-1:0] cnt_raddr, cnt_waddr;
  logic [FW-1:0]          cnt_wdata, cnt_q;
  logic                   win_re, win_we;
  logic [AW-1:0]          win_raddr, win_waddr;
  logic [SYMBOL_BITS-1:0] win_wdata, win_q;

  // Control and window state
  state_t                 state, state_next;
  logic [AW-1:0]          head, head_next;
  logic [FW-1:0]          fill, fill_next;
  logic [DW-1:0]          distinct, distinct_next;
  logic [FW-1:0]          longest, longest_next;
  logic [SYMBOL_BITS-1:0] sym;
  logic [SYMBOL_BITS-1:0] clr_idx;
  logic                   drain_pend, drain_pend_next;
  logic                   evict, evict_next;
  logic                   ovf, ovf_next;
  logic [DISTINCT_W-1:0]  max_distinct;
  logic                   out_load;

  logic [AW-1:0]          head_inc;
  logic [FW-1:0]          pos_sum;
  logic [AW-1:0]          pos;
  logic                   in_acc, cfg_wr;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MAX_DISTINCT) ? APB_DW'(max_distinct) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distinct <= MAX_DISTINCT_RESET;
    end else if (cfg_wr && paddr[2] == REG_MAX_DISTINCT) begin
      max_distinct <= pwdata[DISTINCT_W-1:0];
    end
  end

  // Circular buffer addressing
  assign head_inc = (head == AW'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1;
  assign pos_sum  = FW'(head) + fill;
  assign pos      = (pos_sum >= FW'(WINDOW_DEPTH)) ? AW'(pos_sum - FW'(WINDOW_DEPTH))
                                                   : AW'(pos_sum);

  // Memories: one read and one write port each, registered read data
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_q <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_waddr] <= win_wdata;
    end
    if (win_re) begin
      win_q <= win_mem[win_raddr];
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      head       <= '0;
      fill       <= '0;
      distinct   <= '0;
      longest    <= '0;
      clr_idx    <= '0;
      drain_pend <= 1'b0;
      evict      <= 1'b0;
      ovf        <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      fill       <= fill_next;
      distinct   <= distinct_next;
      longest    <= longest_next;
      drain_pend <= drain_pend_next;
      evict      <= evict_next;
      ovf        <= ovf_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sym <= SYMBOL_BITS'(symbol);
    end
  end

  // Sequencer: next state and memory controls
  always_comb begin
    state_next      = state;
    head_next       = head;
    fill_next       = fill;
    distinct_next   = distinct;
    longest_next    = longest;
    drain_pend_next = 1'b0;
    evict_next      = evict;
    ovf_next        = ovf;
    out_load        = 1'b0;
    cnt_re          = 1'b0;
    cnt_raddr       = sym;
    cnt_we          = 1'b0;
    cnt_waddr       = sym;
    cnt_wdata       = '0;
    win_re          = 1'b0;
    win_raddr       = head;
    win_we          = 1'b0;
    win_waddr       = pos;
    win_wdata       = sym;

    case (state)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx;
        if (clr_idx == '1) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          ovf_next   = 1'b0;
          evict_next = 1'b0;
          state_next = first ? ST_DRAIN : ST_START;
        end
      end

      // read each buffered symbol, zero its count in the following cycle
      ST_DRAIN: begin
        if (drain_pend) begin
          cnt_we    = 1'b1;
          cnt_waddr = win_q;
        end
        if (fill != '0) begin
          win_re          = 1'b1;
          head_next       = head_inc;
          fill_next       = fill - 1'b1;
          drain_pend_next = 1'b1;
        end else if (!drain_pend) begin
          head_next     = '0;
          distinct_next = '0;
          longest_next  = '0;
          state_next    = ST_START;
        end
      end

      ST_START: begin
        if (fill == FW'(WINDOW_DEPTH)) begin
          ovf_next   = 1'b1;
          evict_next = 1'b1;
          state_next = ST_DROP_A;
        end else begin
          state_next = ST_INS_A;
        end
      end

      ST_DROP_A: begin
        win_re     = 1'b1;
        state_next = ST_DROP_B;
      end

      ST_DROP_B: begin
        cnt_re     = 1'b1;
        cnt_raddr  = win_q;
        state_next = ST_DROP_C;
      end

      ST_DROP_C: begin
        if (cnt_q != '0) begin
          cnt_we    = 1'b1;
          cnt_waddr = win_q;
          cnt_wdata = cnt_q - 1'b1;
          if (cnt_q == FW'(1) && distinct != '0) begin
            distinct_next = distinct - 1'b1;
          end
        end
        head_next  = head_inc;
        fill_next  = fill - 1'b1;
        evict_next = 1'b0;
        state_next = evict ? ST_INS_A : ST_CHECK;
      end

      ST_INS_A: begin
        win_we     = 1'b1;
        cnt_re     = 1'b1;
        state_next = ST_INS_B;
      end

      ST_INS_B: begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_q + 1'b1;
        if (cnt_q == '0) begin
          distinct_next = distinct + 1'b1;
        end
        fill_next  = fill + 1'b1;
        state_next = ST_CHECK;
      end

      // shrink while over the limit, then publish once the output is free
      ST_CHECK: begin
        if (CMPW'(distinct) > CMPW'(max_distinct) && fill != '0) begin
          state_next = ST_DROP_A;
        end else if (!out_valid || out_ready) begin
          if (fill > longest) begin
            longest_next = fill;
          end
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      best_length    <= LEN_W'(longest_next);
      window_length  <= LEN_W'(fill);
      distinct_count <= DISTINCT_W'(distinct);
      overflow       <= ovf;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW_DEPTH))
    else $error("window fill exceeds buffer depth");

  a_idle_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (FW'(distinct) <= fill || FW'(distinct) == '0))
    else $error("distinct symbols exceed window length at rest");

  a_idle_longest: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (fill <= longest))
    else $error("best length below current window length");

  a_insert_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_B) |=> (fill != '0))
    else $error("window empty right after an insert");

endmodule

`default_nettype wire

[verif/tb_longest_window_k_distinct.sv]
// Self-checking testbench for longest_window_k_distinct: directed table, then
// random strings, a many-symbol string and a long shrink.
// Depends on lwkd_pkg and the longest_window_k_distinct RTL.
`timescale 1ns / 1ps

module tb_longest_window_k_distinct;
  import lwkd_pkg::*;

  localparam int DEPTH        = DEFAULT_WINDOW_DEPTH;
  localparam int NUM_SYM      = 1 << DEFAULT_SYMBOL_BITS;
  localparam int STALL_LIMIT  = 5000;
  localparam logic [APB_AW-1:0] ADDR_MAX_DISTINCT = {REG_MAX_DISTINCT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED     = {~REG_MAX_DISTINCT, 2'b00};

  typedef struct packed {
    logic [LEN_W-1:0]      best;
    logic [LEN_W-1:0]      wlen;
    logic [DISTINCT_W-1:0] dcnt;
    logic                  ovf;
  } window_result_t;

  typedef struct {
    bit                  do_cfg;
    logic [APB_AW-1:0]   cfg_addr;
    logic [APB_DW-1:0]   cfg_data;
    logic [SYM_IN_W-1:0] sym;
    logic                fst;
    bit                  typed;
    window_result_t      res;
  } stim_row_t;

  // DUT signals
  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [SYM_IN_W-1:0]   symbol;
  logic                  first;
  logic                  out_valid;
  logic                  out_ready;
  logic [LEN_W-1:0]      best_length;
  logic [LEN_W-1:0]      window_length;
  logic [DISTINCT_W-1:0] distinct_count;
  logic                  overflow;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  longest_window_k_distinct uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .symbol(symbol), .first(first),
    .out_valid(out_valid), .out_ready(out_ready),
    .best_length(best_length), .window_length(window_length),
    .distinct_count(distinct_count), .overflow(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: a private copy of the window
  int unsigned          sym_count [NUM_SYM];
  logic [SYM_IN_W-1:0]  win_buf [DEPTH];
  int unsigned          win_head;
  int unsigned          win_fill;
  int unsigned          distinct_held;
  int unsigned          longest;
  logic [DISTINCT_W-1:0] limit_reg;

  window_result_t window_results_due[$];
  stim_row_t      stim_table[$];
  int unsigned    err_count;
  int unsigned    stall_cycles;
  int             burst_left;
  bit             gaps_on;
  int unsigned    rcv_tick;
  int unsigned    rcv_mode;
  window_result_t due;

  function automatic void clear_window();
    for (int i = 0; i < NUM_SYM; i++) sym_count[i] = 0;
    win_head = 0;
    win_fill = 0;
    distinct_held = 0;
    longest = 0;
  endfunction

  function automatic void drop_oldest();
    logic [SYM_IN_W-1:0] s;
    if (win_fill == 0) return;
    s = win_buf[win_head];
    if (sym_count[s] != 0) begin
      sym_count[s]--;
      if (sym_count[s] == 0 && distinct_held != 0) distinct_held--;
    end
    win_head = (win_head + 1) % DEPTH;
    win_fill--;
  endfunction

  // Expected result of one request; updates the predictor state
  function automatic window_result_t advance_window(input logic [SYM_IN_W-1:0] sym,
                                                    input logic fst);
    window_result_t r;
    int unsigned pos;
    r.ovf = 1'b0;
    if (fst) clear_window();
    // full buffer: evict before the new symbol enters
    if (win_fill >= DEPTH) begin
      drop_oldest();
      r.ovf = 1'b1;
    end
    pos = (win_head + win_fill) % DEPTH;
    win_buf[pos] = sym;
    win_fill++;
    if (sym_count[sym] == 0) distinct_held++;
    sym_count[sym]++;
    while (distinct_held > 32'(limit_reg) && win_fill > 0) drop_oldest();
    if (win_fill > longest) longest = win_fill;
    r.best = LEN_W'(longest);
    r.wlen = LEN_W'(win_fill);
    r.dcnt = DISTINCT_W'(distinct_held);
    return r;
  endfunction

  function automatic void report_mismatch(input string field, input int unsigned exp_v,
                                          input int unsigned act_v);
    err_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
  endfunction

  function automatic void add_row(input int do_cfg, input logic [APB_AW-1:0] addr,
                                  input logic [APB_DW-1:0] data,
                                  input logic [SYM_IN_W-1:0] sym, input int fst,
                                  input int typed, input int best, input int wlen,
                                  input int dcnt, input int ovf);
    stim_row_t row;
    row.do_cfg = (do_cfg != 0);
    row.cfg_addr = addr;
    row.cfg_data = data;
    row.sym = sym;
    row.fst = (fst != 0);
    row.typed = (typed != 0);
    row.res.best = LEN_W'(best);
    row.res.wlen = LEN_W'(wlen);
    row.res.dcnt = DISTINCT_W'(dcnt);
    row.res.ovf = (ovf != 0);
    stim_table.insert(stim_table.size(), row);
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (window_results_due.size() == 0) begin
          err_count++;
          $display("%0t: result with no request pending, actual best %0d window %0d",
                   $time, best_length, window_length);
        end else begin
          due = window_results_due[0];
          window_results_due.delete(0);
          if (best_length !== due.best)
            report_mismatch("best_length", 32'(due.best), 32'(best_length));
          if (window_length !== due.wlen)
            report_mismatch("window_length", 32'(due.wlen), 32'(window_length));
          if (distinct_count !== due.dcnt)
            report_mismatch("distinct_count", 32'(due.dcnt), 32'(distinct_count));
          if (overflow !== due.ovf)
            report_mismatch("overflow", 32'(due.ovf), 32'(overflow));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, stall_cycles);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // Receiver: backpressure pattern drawn at random from four modes
  initial begin
    out_ready = 1'b0;
    rcv_tick = 0;
    rcv_mode = 0;
    forever begin
      @(negedge clk);
      rcv_tick++;
      if (rcv_tick % 48 == 0) rcv_mode = $urandom_range(0, 3);
      case (rcv_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((rcv_tick % 16) >= 12);
      endcase
    end
  end

  // Send one request; bursts of random length with random gaps between them
  task automatic send_item(input logic [SYM_IN_W-1:0] sym, input logic fst,
                           input bit typed, input window_result_t typed_res);
    int gap;
    window_result_t r;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (!gaps_on || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    symbol <= sym;
    first <= fst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = advance_window(sym, fst);
    window_results_due.insert(window_results_due.size(), typed ? typed_res : r);
    burst_left--;
    @(negedge clk);
  endtask

  // Hold the sender until every pending result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (window_results_due.size() != 0);
  endtask

  task automatic apb_access(input bit wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_limit();
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, ADDR_MAX_DISTINCT, '0, rd);
    if (rd[DISTINCT_W-1:0] !== limit_reg)
      report_mismatch("max_distinct readback", 32'(limit_reg), 32'(rd[DISTINCT_W-1:0]));
  endtask

  // Register write while the block is idle, then read back
  task automatic write_cfg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    logic [APB_DW-1:0] rd;
    drain_results();
    repeat (8) @(negedge clk);
    apb_access(1'b1, addr, data, rd);
    if (addr == ADDR_MAX_DISTINCT) limit_reg = data[DISTINCT_W-1:0];
    check_limit();
  endtask

  // One string over a small random alphabet, with some noise and stray first flags
  task automatic send_string(input int len, input int alpha_n);
    logic [SYM_IN_W-1:0] alpha [8];
    logic [SYM_IN_W-1:0] s;
    logic f;
    for (int i = 0; i < 8; i++) alpha[i] = SYM_IN_W'($urandom_range(0, NUM_SYM - 1));
    for (int i = 0; i < len; i++) begin
      s = ($urandom_range(0, 9) == 0) ? SYM_IN_W'($urandom_range(0, NUM_SYM - 1))
                                      : alpha[$urandom_range(0, alpha_n - 1)];
      f = (i == 0) || ($urandom_range(0, 49) == 0);
      send_item(s, f, 1'b0, '0);
    end
  endtask

  function automatic logic [DISTINCT_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return DISTINCT_W'(0);
      1: return DISTINCT_W'(1);
      2: return DISTINCT_W'(2);
      3: return DISTINCT_W'(3);
      4: return DISTINCT_W'(256);
      5: return DISTINCT_W'(511);
      6: return DISTINCT_W'($urandom_range(0, 511));
      default: return DISTINCT_W'($urandom_range(4, 8));
    endcase
  endfunction

  // Main sequence
  initial begin
    int sent;
    int len;
    logic [SYM_IN_W-1:0] perm [NUM_SYM];
    logic [SYM_IN_W-1:0] tmp;
    logic [SYM_IN_W-1:0] sa;
    logic [SYM_IN_W-1:0] sb;
    int j;

    rst = 1'b1;
    in_valid = 1'b0;
    symbol = '0;
    first = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_count = 0;
    stall_cycles = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    limit_reg = MAX_DISTINCT_RESET;
    for (int i = 0; i < DEPTH; i++) win_buf[i] = '0;
    clear_window();

    // Directed table: limit 2 after reset, then limit zero, one, above the
    // symbol count, an ignored write, masked write data and mid-string changes
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd0, 1, 1, 1, 1, 1, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd255, 0, 1, 2, 2, 2, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd255, 0, 1, 3, 3, 2, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd7, 0, 1, 3, 3, 2, 0);
    add_row(1, ADDR_MAX_DISTINCT, 0, 8'd0, 1, 1, 0, 0, 0, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd255, 0, 1, 0, 0, 0, 0);
    add_row(1, ADDR_MAX_DISTINCT, 1, 8'd5, 1, 1, 1, 1, 1, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd5, 0, 1, 2, 2, 1, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd6, 0, 1, 2, 1, 1, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd6, 0, 1, 2, 2, 1, 0);
    add_row(1, ADDR_MAX_DISTINCT, 511, 8'd170, 1, 1, 1, 1, 1, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd85, 0, 1, 2, 2, 2, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd170, 0, 1, 3, 3, 2, 0);
    add_row(1, ADDR_UNMAPPED, 0, 8'd1, 0, 1, 4, 4, 3, 0);
    add_row(1, ADDR_MAX_DISTINCT, 32'hFFFF_FE03, 8'd1, 1, 1, 1, 1, 1, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd2, 0, 1, 2, 2, 2, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd3, 0, 1, 3, 3, 3, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd4, 0, 1, 3, 3, 3, 0);
    add_row(1, ADDR_MAX_DISTINCT, 256, 8'd128, 0, 0, 0, 0, 0, 0);
    add_row(1, ADDR_MAX_DISTINCT, 2, 8'd128, 0, 0, 0, 0, 0, 0);
    add_row(1, ADDR_MAX_DISTINCT, 0, 8'd9, 0, 0, 0, 0, 0, 0);
    add_row(0, ADDR_MAX_DISTINCT, 0, 8'd200, 1, 0, 0, 0, 0, 0);

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    check_limit();

    foreach (stim_table[i]) begin
      if (stim_table[i].do_cfg) write_cfg(stim_table[i].cfg_addr, stim_table[i].cfg_data);
      send_item(stim_table[i].sym, stim_table[i].fst, stim_table[i].typed,
                stim_table[i].res);
    end

    // Random phases: each with its own limit, mostly well-formed strings
    for (int phase = 0; phase < 6; phase++) begin
      if ($urandom_range(0, 3) == 0) write_cfg(ADDR_UNMAPPED, $urandom);
      write_cfg(ADDR_MAX_DISTINCT,
                {APB_DW'($urandom_range(0, 8388607)) << DISTINCT_W} | pick_limit());
      sent = 0;
      while (sent < 25) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 25);
        send_string(len, $urandom_range(1, 6));
        sent += len;
        if (phase == 3 || $urandom_range(0, 3) == 0) drain_results();
      end
    end

    // Many different symbol values in one string, limit equal to the symbol count
    gaps_on = 1'b0;
    write_cfg(ADDR_MAX_DISTINCT, 256);
    for (int i = 0; i < NUM_SYM; i++) perm[i] = SYM_IN_W'(i);
    for (int i = NUM_SYM - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < 64; i++) send_item(perm[i], i == 0, 1'b0, '0);

    // Two-symbol string, then a third symbol forces a long shrink, then a new
    // string clears the window
    gaps_on = 1'b1;
    write_cfg(ADDR_MAX_DISTINCT, 2);
    sa = SYM_IN_W'($urandom_range(0, NUM_SYM - 1));
    sb = sa ^ SYM_IN_W'($urandom_range(1, NUM_SYM - 2));
    for (int i = 0; i < 60; i++)
      send_item(($urandom_range(0, 1) == 0) ? sa : sb, i == 0, 1'b0, '0);
    send_item(~sa, 1'b0, 1'b0, '0);
    for (int i = 0; i < 10; i++) send_item(($urandom_range(0, 1) == 0) ? sa : ~sa,
                                           1'b0, 1'b0, '0);
    send_item(sb, 1'b1, 1'b0, '0);

    drain_results();
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[longest_window_k_distinct.f]
rtl/lwkd_pkg.sv
rtl/longest_window_k_distinct.sv
verif/tb_longest_window_k_distinct.sv
